// ----- design/altitude_dual_rate_filter_defines.svh -----
// Assertion macros shared by the altitude dual-rate filter checkers.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ALTITUDE_DUAL_RATE_FILTER_DEFINES_SVH
`define ALTITUDE_DUAL_RATE_FILTER_DEFINES_SVH

// Same-cycle implication
`define ADRF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ADRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles
`define ADRF_ASSERT_DELAY(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ## n (cons)) \
		else $error(msg);

`endif

// ----- design/adrf_pkg.sv -----
// Package for the altitude dual-rate filter: widths, reset values,
// register indexes and sequencer states. No dependencies.
package adrf_pkg;

	// Field and state widths
	localparam int SAMPLE_W   = 24;
	localparam int DIFF_W     = 17;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int SUM_W      = 30;
	localparam int ACC_W      = 40;
	localparam int FRAC_W     = 16;

	// Sample ring
	localparam int RING_DEPTH = 32;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	// Default averaging window
	localparam int WINDOW_DEFAULT = 25;

	// Register reset values
	localparam logic [CFG_W-1:0] SLOW_WEIGHT_RST     = 16'd655;
	localparam logic [CFG_W-1:0] JUMP_THRESHOLD_RST  = 16'd51;
	localparam logic [CFG_W-1:0] CLAMP_LIMIT_RST     = 16'd256;
	localparam logic [CFG_W-1:0] CORRECTION_GAIN_RST = 16'd10923;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOW_WEIGHT,
		REG_JUMP_THRESHOLD,
		REG_CLAMP_LIMIT,
		REG_CORRECTION_GAIN
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,   // wait for a sample, issue ring read
		ST_SUM,    // ring write-back, running sum update, magnitude
		ST_DIV,    // reciprocal multiply
		ST_FIX,    // quotient correction and sign
		ST_MULW,   // baseline weight multiply
		ST_UPD,    // baseline accumulate
		ST_DIFF,   // difference, clamp, threshold compare
		ST_CORR    // correction, saturation, result load
	} state_t;

endpackage

// ----- design/adrf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module adrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/altitude_dual_rate_filter.sv -----
// Altitude dual-rate filter: window mean plus slow tracking baseline.
// A new sample is taken only in idle; the sequencer walks ring read, sum, reciprocal
// divide, quotient fix, baseline multiply and accumulate, clamp and correction through
// one shared datapath, and waits in correction while a held result stalls the output.
// Reset (arst_n, async): sequencer idle, running sum, baseline, write index and
// ring valid bits cleared, registers to defaults; unwritten ring slots read as 0.
// Depends on adrf_pkg and adrf_ram.
module altitude_dual_rate_filter #(
	parameter int WINDOW = adrf_pkg::WINDOW_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [adrf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [adrf_pkg::CFG_W-1:0]           cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [adrf_pkg::SAMPLE_W-1:0] altitude_sample,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [adrf_pkg::SAMPLE_W-1:0] fast_altitude,
	output logic signed [adrf_pkg::SAMPLE_W-1:0] slow_altitude,
	output logic signed [adrf_pkg::DIFF_W-1:0]   clamped_difference
);
	import adrf_pkg::*;

	// Divide by WINDOW as multiply by a truncated reciprocal plus one correction
	localparam int MAG_W     = SUM_W - 1;
	localparam int RECIP_SH  = MAG_W + 1;
	localparam int RECIP_W   = RECIP_SH + 1;
	localparam int PRODD_W   = MAG_W + RECIP_W;
	localparam int WIN_W     = $clog2(WINDOW + 1);
	localparam logic [RECIP_W-1:0]  RECIP_M = RECIP_W'((64'd1 << RECIP_SH) / WINDOW);
	localparam logic [WIN_W-1:0]    WIN_C   = WIN_W'(WINDOW);
	localparam logic [RING_AW:0]    WIN_IDX = (RING_AW + 1)'(WINDOW);
	localparam int WPROD_W   = ACC_W + 1 + CFG_W + 1;
	localparam int CPROD_W   = DIFF_W + CFG_W + 1;

	// Control state
	state_t                 state_q, state_d;
	logic [RING_AW-1:0]     widx_q;
	logic [RING_DEPTH-1:0]  ring_vld_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                   out_valid_q;

	// Registers
	logic [CFG_W-1:0] slow_weight_q, jump_threshold_q, clamp_limit_q, correction_gain_q;

	// Working registers
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [RING_AW-1:0]         idx_q;
	logic                       old_vld_q;
	logic [MAG_W-1:0]           mag_q;
	logic                       neg_q;
	logic [MAG_W-1:0]           quot_q;
	logic signed [SAMPLE_W-1:0] fast_q;
	logic signed [WPROD_W-1:0]  wprod_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic                       corr_q;

	// Output registers
	logic signed [SAMPLE_W-1:0] out_fast_q, out_slow_q;
	logic signed [DIFF_W-1:0]   out_diff_q;

	// Combinational
	logic                       in_acc;
	logic                       out_free;
	logic                       out_load;
	logic [RING_AW-1:0]         idx_sel;
	logic [RING_AW:0]           idx_inc;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SAMPLE_W-1:0] old_sample;
	logic signed [SUM_W-1:0]    sum_new;
	logic [PRODD_W-1:0]         prod_div;
	logic [MAG_W-1:0]           quot_w;
	logic [MAG_W-1:0]           rem;
	logic [MAG_W-1:0]           quot_fix;
	logic signed [SAMPLE_W:0]   fast_ext;
	logic signed [ACC_W:0]      wdelta;
	logic signed [CFG_W:0]      weight_s;
	logic signed [SAMPLE_W-1:0] slow_cur;
	logic signed [SAMPLE_W:0]   diff_raw;
	logic signed [SAMPLE_W:0]   lim_s;
	logic signed [SAMPLE_W:0]   diff_clamp;
	logic [SAMPLE_W:0]          diff_mag;
	logic signed [CFG_W:0]      gain_s;
	logic signed [CPROD_W-1:0]  cprod;
	logic signed [ACC_W:0]      acc_sum;
	logic signed [ACC_W-1:0]    acc_new;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == ST_CORR) && out_free;

	// Ring slot for this sample; an out-of-window index restarts at slot 0
	assign idx_sel = ({1'b0, widx_q} >= WIN_IDX) ? '0 : widx_q;
	assign idx_inc = {1'b0, idx_q} + (RING_AW + 1)'(1);

	// Sample ring; written in ST_SUM, next read no earlier than the next item
	adrf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_SUM),
		.waddr (idx_q),
		.wdata (sample_q),
		.re    (in_acc),
		.raddr (idx_sel),
		.rdata (ram_rdata)
	);

	// Running sum and its magnitude
	assign old_sample = old_vld_q ? $signed(ram_rdata) : '0;
	assign sum_new    = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);

	// Reciprocal quotient estimate, low by at most one
	assign prod_div = mag_q * RECIP_M;

	// Quotient correction
	assign quot_w   = MAG_W'(quot_q * WIN_C);
	assign rem      = mag_q - quot_w;
	assign quot_fix = (rem >= MAG_W'(WIN_C)) ? quot_q + MAG_W'(1) : quot_q;
	assign fast_ext = neg_q ? -$signed({1'b0, quot_fix[SAMPLE_W-1:0]})
	                        : $signed({1'b0, quot_fix[SAMPLE_W-1:0]});

	// Baseline step toward the fast value
	assign wdelta   = $signed({fast_q, {FRAC_W{1'b0}}}) - (ACC_W + 1)'(acc_q);
	assign weight_s = $signed({1'b0, slow_weight_q});

	// Difference and clamp
	assign slow_cur   = acc_q[ACC_W-1 -: SAMPLE_W];
	assign diff_raw   = (SAMPLE_W + 1)'(fast_q) - (SAMPLE_W + 1)'(slow_cur);
	assign lim_s      = $signed({{(SAMPLE_W + 1 - CFG_W){1'b0}}, clamp_limit_q});
	assign diff_clamp = (diff_raw > lim_s)  ? lim_s :
	                    (diff_raw < -lim_s) ? -lim_s : diff_raw;
	assign diff_mag   = diff_clamp[SAMPLE_W] ? $unsigned(-diff_clamp) : $unsigned(diff_clamp);

	// Correction and saturation
	assign gain_s  = $signed({1'b0, correction_gain_q});
	assign cprod   = diff_q * gain_s;
	assign acc_sum = (ACC_W + 1)'(acc_q) + (corr_q ? (ACC_W + 1)'(cprod) : '0);
	always_comb begin
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
		end else begin
			acc_new = acc_sum[ACC_W-1:0];
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIV;
			ST_DIV:  state_d = ST_FIX;
			ST_FIX:  state_d = ST_MULW;
			ST_MULW: state_d = ST_UPD;
			ST_UPD:  state_d = ST_DIFF;
			ST_DIFF: state_d = ST_CORR;
			ST_CORR: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_weight_q     <= SLOW_WEIGHT_RST;
			jump_threshold_q  <= JUMP_THRESHOLD_RST;
			clamp_limit_q     <= CLAMP_LIMIT_RST;
			correction_gain_q <= CORRECTION_GAIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_SLOW_WEIGHT:     slow_weight_q     <= cfg_data;
				REG_JUMP_THRESHOLD:  jump_threshold_q  <= cfg_data;
				REG_CLAMP_LIMIT:     clamp_limit_q     <= cfg_data;
				REG_CORRECTION_GAIN: correction_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Filter state: index, ring valid bits, running sum, baseline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q     <= '0;
			ring_vld_q <= '0;
			sum_q      <= '0;
			acc_q      <= '0;
		end else begin
			if (state_q == ST_SUM) begin
				ring_vld_q[idx_q] <= 1'b1;
				sum_q             <= sum_new;
				widx_q            <= (idx_inc >= WIN_IDX) ? '0 : idx_inc[RING_AW-1:0];
			end
			if (state_q == ST_UPD) begin
				acc_q <= acc_q + ACC_W'(wprod_q >>> FRAC_W);
			end
			if (out_load) begin
				acc_q <= acc_new;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q  <= altitude_sample;
			idx_q     <= idx_sel;
			old_vld_q <= ring_vld_q[idx_sel];
		end
		if (state_q == ST_SUM) begin
			neg_q <= sum_new[SUM_W-1];
			mag_q <= sum_new[SUM_W-1] ? MAG_W'(-sum_new) : MAG_W'(sum_new);
		end
		if (state_q == ST_DIV) begin
			quot_q <= prod_div[RECIP_SH +: MAG_W];
		end
		if (state_q == ST_FIX) begin
			fast_q <= fast_ext[SAMPLE_W-1:0];
		end
		if (state_q == ST_MULW) begin
			wprod_q <= wdelta * weight_s;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= diff_clamp[DIFF_W-1:0];
			corr_q <= diff_mag > (SAMPLE_W + 1)'(jump_threshold_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fast_q <= fast_q;
			out_slow_q <= acc_new[ACC_W-1 -: SAMPLE_W];
			out_diff_q <= diff_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign fast_altitude      = out_fast_q;
	assign slow_altitude      = out_slow_q;
	assign clamped_difference = out_diff_q;

endmodule

// ----- design/adrf_checker.sv -----
// Port-level checker for the altitude dual-rate filter, bound to the top level.
// Depends on adrf_pkg and altitude_dual_rate_filter_defines.svh.
`include "altitude_dual_rate_filter_defines.svh"

module adrf_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [adrf_pkg::SAMPLE_W-1:0] fast_altitude,
	input logic signed [adrf_pkg::SAMPLE_W-1:0] slow_altitude,
	input logic signed [adrf_pkg::DIFF_W-1:0]   clamped_difference
);

	// A stalled result stays offered
	`ADRF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// A stalled result keeps its payload
	`ADRF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(fast_altitude) && $stable(slow_altitude) && $stable(clamped_difference), "result changed while stalled")

	// One sample at a time: input stays closed while the sequencer runs
	`ADRF_ASSERT_DELAY(a_busy, in_valid && in_ready, 6, !in_ready, "input reopened mid-sequence")

	// A fresh result always traces back to an earlier accepted input transaction
	`ADRF_ASSERT_IMPL(a_result_src, $rose(out_valid), $past(in_valid && in_ready, 8), "result without a matching input transaction")

endmodule

bind altitude_dual_rate_filter adrf_checker u_adrf_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.fast_altitude      (fast_altitude),
	.slow_altitude      (slow_altitude),
	.clamped_difference (clamped_difference)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench for altitude_dual_rate_filter: queue-fed sample driver, result monitor,
// and a bit-accurate window-mean / baseline predictor checked field by field.
// Depends on adrf_pkg and the filter RTL.
module tb;
	import adrf_pkg::*;

	localparam int  WINDOW      = WINDOW_DEFAULT;
	localparam int  CYCLE_LIMIT = 1000000;
	localparam int  PHASES      = 12;
	localparam int  PHASE_ITEMS = 140;
	localparam longint ACC_MAX  = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_MIN  = -(longint'(1) <<< (ACC_W - 1));
	localparam longint ALT_MAX  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint ALT_MIN  = -(longint'(1) <<< (SAMPLE_W - 1));

	typedef struct {
		logic signed [SAMPLE_W-1:0] fast;
		logic signed [SAMPLE_W-1:0] slow;
		logic signed [DIFF_W-1:0]   diff;
	} filter_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] altitude_sample = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] fast_altitude;
	logic signed [SAMPLE_W-1:0] slow_altitude;
	logic signed [DIFF_W-1:0]   clamped_difference;

	// Stimulus and expectation stores
	logic signed [SAMPLE_W-1:0] pending_samples[$];
	filter_result_t             expected_outputs[$];
	int                         error_count = 0;
	int                         cycle_count = 0;
	int                         send_idle_pct = 0;
	int                         recv_stall_pct = 0;
	longint                     walk_level = 0;

	// Predictor state and register copies
	logic signed [SAMPLE_W-1:0] window_ring[RING_DEPTH];
	longint                     window_sum = 0;
	int                         ring_slot = 0;
	longint                     baseline_acc = 0;
	int                         weight_cfg = int'(SLOW_WEIGHT_RST);
	int                         threshold_cfg = int'(JUMP_THRESHOLD_RST);
	int                         clamp_cfg = int'(CLAMP_LIMIT_RST);
	int                         gain_cfg = int'(CORRECTION_GAIN_RST);

	altitude_dual_rate_filter #(.WINDOW(WINDOW)) u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.altitude_sample   (altitude_sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.fast_altitude     (fast_altitude),
		.slow_altitude     (slow_altitude),
		.clamped_difference(clamped_difference)
	);

	always #5 clk = ~clk;

	// Window mean, baseline update, clamp and jump correction for one sample
	function automatic void predict_filter_output(input logic signed [SAMPLE_W-1:0] smp);
		longint         fast, delta, slow_q8, diff, mag;
		int             slot;
		filter_result_t res;
		slot = ring_slot;
		if (slot >= WINDOW)
			slot = 0;
		window_sum = window_sum - window_ring[slot] + smp;
		window_ring[slot] = smp;
		slot++;
		ring_slot = (slot >= WINDOW) ? 0 : slot;
		fast = window_sum / WINDOW;
		delta = (fast <<< FRAC_W) - baseline_acc;
		baseline_acc += (delta * longint'(weight_cfg)) >>> FRAC_W;
		slow_q8 = baseline_acc >>> FRAC_W;
		diff = fast - slow_q8;
		if (diff > clamp_cfg)
			diff = clamp_cfg;
		if (diff < -clamp_cfg)
			diff = -clamp_cfg;
		mag = (diff < 0) ? -diff : diff;
		if (mag > threshold_cfg) begin
			baseline_acc += diff * longint'(gain_cfg);
			if (baseline_acc > ACC_MAX)
				baseline_acc = ACC_MAX;
			if (baseline_acc < ACC_MIN)
				baseline_acc = ACC_MIN;
		end
		res.fast = fast[SAMPLE_W-1:0];
		slow_q8 = baseline_acc >>> FRAC_W;
		res.slow = slow_q8[SAMPLE_W-1:0];
		res.diff = diff[DIFF_W-1:0];
		expected_outputs.push_back(res);
	endfunction

	function automatic void check_field(input string name, input longint exp_v,
			input longint act_v, input logic has_x);
		if (has_x || exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endfunction

	// Sample driver: predicts on each accepted transaction, then offers the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			altitude_sample <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_filter_output(altitude_sample);
			if (!in_valid || in_ready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					altitude_sample <= pending_samples.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		filter_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_outputs.size() == 0) begin
					$display("%0t: unexpected result, fast %0d slow %0d diff %0d", $time,
						fast_altitude, slow_altitude, clamped_difference);
					error_count++;
				end else begin
					exp_r = expected_outputs.pop_front();
					check_field("fast_altitude", exp_r.fast, fast_altitude,
						$isunknown(fast_altitude));
					check_field("slow_altitude", exp_r.slow, slow_altitude,
						$isunknown(slow_altitude));
					check_field("clamped_difference", exp_r.diff, clamped_difference,
						$isunknown(clamped_difference));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_register(input cfg_reg_t idx, input int value);
		case (idx)
			REG_SLOW_WEIGHT:     weight_cfg = value;
			REG_JUMP_THRESHOLD:  threshold_cfg = value;
			REG_CLAMP_LIMIT:     clamp_cfg = value;
			REG_CORRECTION_GAIN: gain_cfg = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Block until the filter has returned every result, then let it settle
	task automatic drain_filter();
		while (pending_samples.size() != 0 || in_valid || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic int pick_register_value();
		case ($urandom_range(5))
			0:       return 0;
			1:       return 65535;
			2:       return $urandom_range(65535);
			default: return $urandom_range(1023);
		endcase
	endfunction

	// Mostly a slow altitude walk with occasional jumps, plus noise and extremes
	function automatic logic signed [SAMPLE_W-1:0] pick_altitude();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return SAMPLE_W'($urandom);
		if (sel < 15)
			return sel[0] ? ALT_MAX[SAMPLE_W-1:0] : ALT_MIN[SAMPLE_W-1:0];
		if (sel < 20)
			walk_level = longint'($urandom_range(16777215)) - 8388608;
		else
			walk_level += longint'($urandom_range(512)) - 256;
		if (walk_level > ALT_MAX)
			walk_level = ALT_MAX;
		if (walk_level < ALT_MIN)
			walk_level = ALT_MIN;
		return walk_level[SAMPLE_W-1:0];
	endfunction

	initial begin
		int p;
		int n;
		for (n = 0; n < RING_DEPTH; n++)
			window_ring[n] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes and bit patterns at default registers
		pending_samples.push_back(ALT_MAX[SAMPLE_W-1:0]);
		pending_samples.push_back(ALT_MIN[SAMPLE_W-1:0]);
		pending_samples.push_back('0);
		pending_samples.push_back(-24'sd1);
		pending_samples.push_back(24'sd1);
		pending_samples.push_back(24'sh555555);
		pending_samples.push_back(24'shAAAAAA);
		pending_samples.push_back(ALT_MAX[SAMPLE_W-1:0]);
		pending_samples.push_back(ALT_MAX[SAMPLE_W-1:0]);
		pending_samples.push_back(ALT_MIN[SAMPLE_W-1:0]);
		pending_samples.push_back(ALT_MIN[SAMPLE_W-1:0]);
		pending_samples.push_back(24'sd300);
		drain_filter();

		// Directed: zero clamp limit means no difference and no correction
		write_register(REG_CLAMP_LIMIT, 0);
		write_register(REG_JUMP_THRESHOLD, 0);
		pending_samples.push_back(ALT_MAX[SAMPLE_W-1:0]);
		pending_samples.push_back(24'sd5000);
		pending_samples.push_back(ALT_MIN[SAMPLE_W-1:0]);
		pending_samples.push_back(-24'sd5000);
		drain_filter();

		// Random phases across register settings and idle patterns
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					write_register(REG_SLOW_WEIGHT, int'(SLOW_WEIGHT_RST));
					write_register(REG_JUMP_THRESHOLD, int'(JUMP_THRESHOLD_RST));
					write_register(REG_CLAMP_LIMIT, int'(CLAMP_LIMIT_RST));
					write_register(REG_CORRECTION_GAIN, int'(CORRECTION_GAIN_RST));
				end
				1, 5: begin
					write_register(REG_SLOW_WEIGHT, 65535);
					write_register(REG_JUMP_THRESHOLD, 0);
					write_register(REG_CLAMP_LIMIT, 65535);
					write_register(REG_CORRECTION_GAIN, 65535);
				end
				2: begin
					write_register(REG_SLOW_WEIGHT, 0);
					write_register(REG_JUMP_THRESHOLD, 0);
					write_register(REG_CLAMP_LIMIT, 0);
					write_register(REG_CORRECTION_GAIN, 0);
				end
				default: begin
					write_register(REG_SLOW_WEIGHT, pick_register_value());
					write_register(REG_JUMP_THRESHOLD, pick_register_value());
					write_register(REG_CLAMP_LIMIT, pick_register_value());
					write_register(REG_CORRECTION_GAIN, pick_register_value());
				end
			endcase
			@(negedge clk);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Long runs at the extremes push the window sum and baseline to their limits
				if ((p == 1 || p == 5) && n < 40)
					pending_samples.push_back(ALT_MAX[SAMPLE_W-1:0]);
				else if ((p == 1 || p == 5) && n < 80)
					pending_samples.push_back(ALT_MIN[SAMPLE_W-1:0]);
				else
					pending_samples.push_back(pick_altitude());
			end
			drain_filter();
		end

		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_outputs.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
